FILE: hdl/hcm_pkg.sv
package hcm_pkg;

  localparam logic [7:0] CharEnd   = 8'h3B;  // ';'
  localparam logic [7:0] CharRead  = 8'h72;  // 'r'
  localparam logic [7:0] CharWrite = 8'h77;  // 'w'
  localparam logic [7:0] CharColon = 8'h3A;  // ':' , entry 0 after reset
  localparam logic [7:0] CaseMask  = 8'hDF;

  typedef struct packed {
    logic        valid;
    logic        is_write;
    logic [15:0] address;
    logic [7:0]  value;
  } req_t;

  // Nibble value as a 16-bit two's complement pattern; non-hex codes are not rejected.
  function automatic logic [15:0] hex_value(input logic [7:0] code);
    logic [15:0] v;
    v = {8'h00, code} - 16'd48;
    if ($signed(v) > 16'sd9) begin
      v = {8'h00, code & CaseMask} - 16'd55;
    end
    return v;
  endfunction

endpackage

FILE: hdl/hcm_decode.sv
module hcm_decode #(
  parameter int LINE_DEPTH = 16,
  localparam int PW = $clog2(LINE_DEPTH)
) (
  input  logic [7:0]    ch_i,
  input  logic [PW-1:0] pos_i,
  input  logic [15:0]   addr_i,
  input  logic [7:0]    store_i [LINE_DEPTH],
  output logic [7:0]    store_o [LINE_DEPTH],
  output logic [PW-1:0] pos_o,
  output logic [15:0]   addr_o,
  output hcm_pkg::req_t req_o
);

  logic [PW-1:0] pos_inc;
  logic [7:0]    line [LINE_DEPTH];
  logic [15:0]   nib [1:6];
  logic [15:0]   parsed_addr;
  logic [7:0]    parsed_data;
  logic          is_end;

  assign pos_inc = (pos_i == PW'(LINE_DEPTH - 1)) ? '0 : pos_i + 1'b1;
  assign is_end  = (ch_i == hcm_pkg::CharEnd);

  // Store the character, then a zero after it.
  always_comb begin
    for (int k = 0; k < LINE_DEPTH; k++) begin
      if (PW'(k) == pos_i) begin
        line[k] = ch_i;
      end else if (PW'(k) == pos_inc) begin
        line[k] = 8'h00;
      end else begin
        line[k] = store_i[k];
      end
    end
  end

  always_comb begin
    for (int k = 1; k <= 6; k++) begin
      nib[k] = hcm_pkg::hex_value(line[k]);
    end
  end

  assign parsed_addr = {nib[1][3:0], 12'h000} + {nib[2][7:0], 8'h00}
                     + {nib[3][11:0], 4'h0} + nib[4];
  assign parsed_data = {nib[5][3:0], 4'h0} | nib[6][7:0];

  always_comb begin
    store_o = line;
    pos_o   = pos_inc;
    addr_o  = addr_i;
    req_o   = '0;
    if (is_end) begin
      priority if (pos_inc == PW'(1)) begin
        // Bare ';' : step to the next address and read it.
        pos_o         = '0;
        addr_o        = addr_i + 16'd1;
        req_o.valid   = 1'b1;
        req_o.address = addr_i + 16'd1;
      end else if (pos_inc != '0) begin
        store_o[0]    = 8'h00;
        pos_o         = '0;
        addr_o        = parsed_addr;
        req_o.address = parsed_addr;
        if (line[0] == hcm_pkg::CharRead) begin
          req_o.valid = 1'b1;
        end else if (line[0] == hcm_pkg::CharWrite) begin
          req_o.valid    = 1'b1;
          req_o.is_write = 1'b1;
          req_o.value    = parsed_data;
        end
      end else begin
        // Position wrapped to zero: nothing beyond the store.
        req_o = '0;
      end
    end
  end

endmodule

FILE: hdl/hex_command_monitor.sv
// A word accepted at the input handshake is held in the input register and decoded
// from there; its request is loaded into the output register when the input register
// advances, which raises out_valid_o.
// Throughput: one word per cycle while out_ready_i is high; a stalled request holds
// one further word in the input register and then drops in_ready_o.
// Reset (rst_ni low, asynchronous): both registers empty, position and address 0,
// line entry 0 set to ':' and all other entries cleared.
module hex_command_monitor #(
  parameter int LINE_DEPTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  character_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        is_write_o,
  output logic [15:0] bus_address_o,
  output logic [7:0]  write_value_o
);

  localparam int PW = $clog2(LINE_DEPTH);

  logic          in_valid_q;
  logic [7:0]    char_q;
  logic [7:0]    store_q [LINE_DEPTH];
  logic [7:0]    store_d [LINE_DEPTH];
  logic [PW-1:0] pos_q, pos_d;
  logic [15:0]   addr_q, addr_d;
  hcm_pkg::req_t req_d;
  logic          out_valid_q;
  logic          is_write_q;
  logic [15:0]   address_q;
  logic [7:0]    value_q;
  logic          adv;

  assign adv        = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || adv;

  hcm_decode #(.LINE_DEPTH(LINE_DEPTH)) u_decode (
    .ch_i   (char_q),
    .pos_i  (pos_q),
    .addr_i (addr_q),
    .store_i(store_q),
    .store_o(store_d),
    .pos_o  (pos_d),
    .addr_o (addr_d),
    .req_o  (req_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      char_q <= character_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < LINE_DEPTH; k++) begin
        store_q[k] <= (k == 0) ? hcm_pkg::CharColon : 8'h00;
      end
      pos_q  <= '0;
      addr_q <= '0;
    end else if (adv) begin
      store_q <= store_d;
      pos_q   <= pos_d;
      addr_q  <= addr_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= req_d.valid;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && req_d.valid) begin
      is_write_q <= req_d.is_write;
      address_q  <= req_d.address;
      value_q    <= req_d.value;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign is_write_o    = is_write_q;
  assign bus_address_o = address_q;
  assign write_value_o = value_q;

  // Every request restarts the line.
  a_req_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && req_d.valid |=> pos_q == '0)
    else $error("request issued without restarting the line");

  // The current address follows the address of the last request.
  a_addr_tracks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && req_d.valid |=> addr_q == bus_address_o)
    else $error("current address differs from issued address");

  // Read requests carry a zero data byte.
  a_read_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !is_write_o |-> write_value_o == 8'h00)
    else $error("read request with nonzero data");

  // A held input word keeps its character while the output stalls.
  a_hold_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !adv |=> in_valid_q && $stable(char_q))
    else $error("stalled input word lost");

endmodule
